@@ rtl/qpt_pkg.sv @@
// shared types, constants and step decode for the quadrature position tracker
`default_nettype none

package qpt_pkg;

    localparam int COUNT_W = 32;
    localparam int SCALE_W = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_W = COUNT_W + SCALE_W;
    localparam int QUOT_W = PROD_W - FRAC_BITS;
    localparam int SUM_W = QUOT_W + 1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_SET_POSITION = 1'b1;

    typedef enum logic [1:0] {
        STEP_NONE = 2'b00,
        STEP_FWD  = 2'b01,
        STEP_REV  = 2'b11
    } step_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] raw_count;
        logic signed [31:0]        offset;
        step_t                     direction;
        logic [31:0]               total;
        logic                      moved;
    } qpt_item_t;

    // old ab code in the high two bits, new ab code in the low two
    function automatic step_t qpt_step(input logic [3:0] idx);
        step_t s;
        case (idx) inside
            4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_FWD;
            4'd2, 4'd4, 4'd11, 4'd13: s = STEP_REV;
            default:                  s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/quadrature_position_tracker_unit.sv @@
// top level of the quadrature position tracker
// path: an accepted item is registered in the queue, then in the multiply stage, then in the output register
// throughput: one item per cycle; the multiply stage and output register stall on out_ready
// a two-entry queue lets the input keep accepting while one result waits to be taken
// reset: asynchronous, active low; clears count, direction, pulse total, offset and scale
`default_nettype none

module quadrature_position_tracker_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [31:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic               pin_a,
    input  wire logic               pin_b,
    input  wire logic signed [31:0] new_position,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      raw_count,
    output logic signed [31:0]      position,
    output logic signed [1:0]       direction,
    output logic [31:0]             total_pulses,
    output logic                    moved
);
    import qpt_pkg::*;

    logic signed [31:0] units_per_count_reg;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    qpt_item_t          push_item, pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_per_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            units_per_count_reg <= cfg_data;
        end
    end

    qpt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .pin_a        (pin_a),
        .pin_b        (pin_b),
        .new_position (new_position),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    qpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    qpt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale        (units_per_count_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .raw_count    (raw_count),
        .position     (position),
        .direction    (direction),
        .total_pulses (total_pulses),
        .moved        (moved)
    );

endmodule

`default_nettype wire

@@ rtl/qpt_front.sv @@
// front end: decodes pin samples and set-position items, holds tracking state
`default_nettype none

module qpt_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         action,
    input  wire logic                         pin_a,
    input  wire logic                         pin_b,
    input  wire logic signed [31:0]           new_position,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output qpt_pkg::qpt_item_t                push_item
);
    import qpt_pkg::*;

    logic [1:0]                prev_ab_reg, prev_ab_next;
    logic signed [COUNT_W-1:0] count_reg, count_next;
    step_t                     dir_reg, dir_next;
    logic [31:0]               total_reg, total_next;
    logic signed [31:0]        offset_reg, offset_next;
    logic                      moved;
    step_t                     step;

    always_comb
    begin
        step         = qpt_step({prev_ab_reg, pin_a, pin_b});
        prev_ab_next = prev_ab_reg;
        count_next   = count_reg;
        dir_next     = dir_reg;
        total_next   = total_reg;
        offset_next  = offset_reg;
        moved        = 1'b0;
        if (action == ACT_SET_POSITION)
        begin
            count_next  = '0;
            offset_next = new_position;
        end
        else
        begin
            prev_ab_next = {pin_a, pin_b};
            if (step != STEP_NONE)
            begin
                count_next = (step == STEP_FWD) ? count_reg + COUNT_W'(1)
                                                : count_reg - COUNT_W'(1);
                dir_next   = step;
                total_next = total_reg + 32'd1;
                moved      = 1'b1;
            end
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_item.raw_count = count_next;
        push_item.offset    = offset_next;
        push_item.direction = dir_next;
        push_item.total     = total_next;
        push_item.moved     = moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg <= '0;
            count_reg   <= '0;
            dir_reg     <= STEP_NONE;
            total_reg   <= '0;
            offset_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            prev_ab_reg <= prev_ab_next;
            count_reg   <= count_next;
            dir_reg     <= dir_next;
            total_reg   <= total_next;
            offset_reg  <= offset_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_moved_bumps_total: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_item.moved) |-> (push_item.total == total_reg + 32'd1))
        else $error("moved item without pulse total increment");

    a_still_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_item.moved) |->
            (push_item.total == total_reg && push_item.raw_count == count_reg
             || action == ACT_SET_POSITION))
        else $error("count or total changed without a step");

    a_set_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && action == ACT_SET_POSITION) |->
            (push_item.raw_count == '0 && !push_item.moved))
        else $error("set position did not clear raw count");
`endif

endmodule

`default_nettype wire

@@ rtl/qpt_queue.sv @@
// two-entry item queue between front and back
`default_nettype none

module qpt_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire qpt_pkg::qpt_item_t  push_item,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output qpt_pkg::qpt_item_t       pop_item
);
    import qpt_pkg::*;

    qpt_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ rtl/qpt_back.sv @@
// back end: scales raw count, adds offset with saturation, drives the result register
`default_nettype none

module qpt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic signed [31:0]  scale,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire qpt_pkg::qpt_item_t  pop_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       raw_count,
    output logic signed [31:0]       position,
    output logic signed [1:0]        direction,
    output logic [31:0]              total_pulses,
    output logic                     moved
);
    import qpt_pkg::*;

    logic                     s1_valid_reg;
    qpt_item_t                s1_item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     s1_ready, s2_ready;

    logic                     out_valid_reg;
    logic signed [31:0]       raw_count_reg, position_reg, position_next;
    logic signed [1:0]        direction_reg;
    logic [31:0]              total_reg;
    logic                     moved_reg;

    logic signed [QUOT_W-1:0] quot;
    logic                     round_up;
    logic signed [SUM_W-1:0]  sum;

    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;

    // truncate toward zero: floor shift plus one when negative with a fraction
    always_comb
    begin
        quot     = prod_reg[PROD_W-1:FRAC_BITS];
        round_up = prod_reg[PROD_W-1] && (|prod_reg[FRAC_BITS-1:0]);
        sum      = SUM_W'(s1_item_reg.offset) + SUM_W'(quot) + SUM_W'({1'b0, round_up});
        if (sum > SUM_W'(32'sh7fffffff))
        begin
            position_next = 32'sh7fffffff;
        end
        else if (sum < SUM_W'(-33'sh80000000))
        begin
            position_next = -32'sh80000000;
        end
        else
        begin
            position_next = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && s1_ready)
        begin
            s1_item_reg <= pop_item;
            prod_reg    <= pop_item.raw_count * PROD_W'(scale);
        end
        if (s1_valid_reg && s2_ready)
        begin
            raw_count_reg <= s1_item_reg.raw_count[31:0];
            position_reg  <= position_next;
            direction_reg <= s1_item_reg.direction;
            total_reg     <= s1_item_reg.total;
            moved_reg     <= s1_item_reg.moved;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign raw_count    = raw_count_reg;
    assign position     = position_reg;
    assign direction    = direction_reg;
    assign total_pulses = total_reg;
    assign moved        = moved_reg;

`ifndef NO_ASSERTIONS
    a_zero_scale_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready && scale == '0) |=> (position_reg == $past(s1_item_reg.offset)))
        else $error("zero scale must pass offset through");

    a_no_load_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg)
        else $error("stage one item dropped under stall");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the quadrature position tracker: directed rows, then random checked phases
`default_nettype none

module tb;
    import qpt_pkg::*;

    localparam int LATENCY = 3;
    localparam int QUIET_LIMIT = 1000;
    localparam int N_PHASES = 6;
    localparam int N_ROWS = 23;

    typedef struct {
        logic [31:0] raw;
        logic [31:0] pos;
        step_t       dir;
        logic [31:0] total;
        logic        moved;
    } reading_t;

    typedef struct {
        logic        act;
        logic        a;
        logic        b;
        logic [31:0] np;
        bit          typed;
        reading_t    given;
    } row_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic signed [31:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              action = ACT_SAMPLE;
    logic              pin_a = 1'b0;
    logic              pin_b = 1'b0;
    logic signed [31:0] new_position = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [31:0] raw_count;
    logic signed [31:0] position;
    logic signed [1:0] direction;
    logic [31:0]       total_pulses;
    logic              moved;

    quadrature_position_tracker_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .pin_a(pin_a),
        .pin_b(pin_b),
        .new_position(new_position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .raw_count(raw_count),
        .position(position),
        .direction(direction),
        .total_pulses(total_pulses),
        .moved(moved)
    );

    // tracker state mirrored by the predictor
    logic [1:0] ab_prev = 2'b00;
    int         count_now = 0;
    step_t      dir_now = STEP_NONE;
    int unsigned pulses_now = 0;
    int         offset_now = 0;
    int         scale_now = 0;

    reading_t pending_readings[$];
    int       mismatches = 0;
    int       tx_idle_pct = 0;
    int       rx_stall_pct = 0;
    int       hold_left = 0;
    int       quiet = 0;

    // stimulus walk state
    logic [1:0] walk_ab = 2'b00;
    bit         walk_fwd = 1'b1;

    row_t script [N_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int step_of(input logic [3:0] idx);
        int s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  s = 1;
            4'd2, 4'd4, 4'd11, 4'd13: s = -1;
            default:                  s = 0;
        endcase
        return s;
    endfunction

    function automatic reading_t decode_and_scale(input logic act, input logic a, input logic b,
                                                  input logic [31:0] np);
        reading_t r;
        int       s;
        longint   pos;
        longint   rmag;
        longint   smag;
        longint   mag;
        r.moved = 1'b0;
        if (act == ACT_SET_POSITION)
        begin
            count_now = 0;
            offset_now = int'(np);
        end
        else
        begin
            s = step_of({ab_prev, a, b});
            if (s != 0)
            begin
                count_now = count_now + s;
                dir_now = (s > 0) ? STEP_FWD : STEP_REV;
                pulses_now = pulses_now + 1;
                r.moved = 1'b1;
            end
            ab_prev = {a, b};
        end
        pos = longint'(offset_now);
        if (scale_now != 0)
        begin
            rmag = (count_now < 0) ? -longint'(count_now) : longint'(count_now);
            smag = (scale_now < 0) ? -longint'(scale_now) : longint'(scale_now);
            // truncation toward zero: shift the magnitude, then apply the sign
            mag = (rmag * smag) >>> FRAC_BITS;
            pos = pos + (((count_now < 0) != (scale_now < 0)) ? -mag : mag);
        end
        if (pos > 64'sd2147483647)
            pos = 64'sd2147483647;
        if (pos < -64'sd2147483648)
            pos = -64'sd2147483648;
        r.raw = count_now;
        r.pos = pos[31:0];
        r.dir = dir_now;
        r.total = pulses_now;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // receiver: random stalls, one long hold on request, result checking
    always @(posedge clk)
    begin
        reading_t want;
        if (out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: raw %h position %h", raw_count, position);
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("raw_count", want.raw, raw_count);
                check_field("position", want.pos, position);
                check_field("direction", {30'd0, want.dir}, {30'd0, direction});
                check_field("total_pulses", want.total, total_pulses);
                check_field("moved", {31'd0, want.moved}, {31'd0, moved});
            end
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("** quadrature_position_tracker_unit: FAILED **");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic write_scale(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scale_now = int'(v);
    endtask

    task automatic offer(input logic act, input logic a, input logic b, input logic [31:0] np,
                         input bit typed, input reading_t given);
        reading_t r;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        pin_a <= a;
        pin_b <= b;
        new_position <= np;
        do @(posedge clk); while (!in_ready);
        r = decode_and_scale(act, a, b, np);
        pending_readings.push_back(typed ? given : r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // mostly clean gray-code walks with runs in one direction, some holds, noise and resets
    task automatic next_random(output logic act, output logic a, output logic b,
                               output logic [31:0] np);
        int r;
        r = $urandom_range(99);
        np = $urandom;
        act = ACT_SAMPLE;
        if (r < 3)
        begin
            act = ACT_SET_POSITION;
            case ($urandom_range(7))
                0: np = 32'h7FFF_FFFF;
                1: np = 32'h8000_0000;
                2: np = 32'h0000_0000;
                3: np = 32'hFFFF_FFFF;
                4: np = $urandom_range(2000) - 1000;
                default: np = $urandom;
            endcase
            {a, b} = 2'($urandom_range(3));
        end
        else if (r < 8)
        begin
            walk_ab = 2'($urandom_range(3));
            {a, b} = walk_ab;
        end
        else if (r < 20)
            {a, b} = walk_ab;
        else
        begin
            if ($urandom_range(99) < 5)
                walk_fwd = !walk_fwd;
            if (walk_fwd)
                case (walk_ab)
                    2'b00: walk_ab = 2'b01;
                    2'b01: walk_ab = 2'b11;
                    2'b11: walk_ab = 2'b10;
                    default: walk_ab = 2'b00;
                endcase
            else
                case (walk_ab)
                    2'b00: walk_ab = 2'b10;
                    2'b10: walk_ab = 2'b11;
                    2'b11: walk_ab = 2'b01;
                    default: walk_ab = 2'b00;
                endcase
            {a, b} = walk_ab;
        end
    endtask

    initial
    begin
        reading_t    none;
        logic        act;
        logic        a;
        logic        b;
        logic [31:0] np;
        int unsigned ph_scale [N_PHASES];
        int          ph_tx [N_PHASES];
        int          ph_rx [N_PHASES];
        int          ph_len [N_PHASES];

        none = '{32'd0, 32'd0, STEP_NONE, 32'd0, 1'b0};
        script[0]  = '{ACT_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b1,
                       '{32'd0, 32'd0, STEP_NONE, 32'd0, 1'b0}};
        script[1]  = '{ACT_SAMPLE, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1,
                       '{32'd1, 32'd0, STEP_FWD, 32'd1, 1'b1}};
        script[2]  = '{ACT_SAMPLE, 1'b1, 1'b1, 32'h0, 1'b0, none};
        script[3]  = '{ACT_SAMPLE, 1'b1, 1'b0, 32'h0, 1'b0, none};
        script[4]  = '{ACT_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b0, none};
        script[5]  = '{ACT_SAMPLE, 1'b1, 1'b0, 32'h0, 1'b0, none};
        script[6]  = '{ACT_SAMPLE, 1'b1, 1'b1, 32'h0, 1'b0, none};
        script[7]  = '{ACT_SAMPLE, 1'b0, 1'b1, 32'h0, 1'b0, none};
        script[8]  = '{ACT_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b0, none};
        script[9]  = '{ACT_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b0, none};
        // both pins change at once: no step
        script[10] = '{ACT_SAMPLE, 1'b1, 1'b1, 32'h0, 1'b1,
                       '{32'd0, 32'd0, STEP_REV, 32'd8, 1'b0}};
        script[11] = '{ACT_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b1,
                       '{32'd0, 32'd0, STEP_REV, 32'd8, 1'b0}};
        script[12] = '{ACT_SAMPLE, 1'b1, 1'b0, 32'h0, 1'b0, none};
        script[13] = '{ACT_SET_POSITION, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1,
                       '{32'd0, 32'h7FFF_FFFF, STEP_REV, 32'd9, 1'b0}};
        script[14] = '{ACT_SET_POSITION, 1'b1, 1'b1, 32'h8000_0000, 1'b1,
                       '{32'd0, 32'h8000_0000, STEP_REV, 32'd9, 1'b0}};
        // pins kept across set position
        script[15] = '{ACT_SAMPLE, 1'b1, 1'b0, 32'h5A5A_5A5A, 1'b0, none};
        script[16] = '{ACT_SAMPLE, 1'b1, 1'b1, 32'hA5A5_A5A5, 1'b0, none};
        script[17] = '{ACT_SAMPLE, 1'b1, 1'b1, 32'h0, 1'b0, none};
        script[18] = '{ACT_SAMPLE, 1'b0, 1'b1, 32'h0, 1'b0, none};
        script[19] = '{ACT_SAMPLE, 1'b0, 1'b1, 32'h0, 1'b0, none};
        script[20] = '{ACT_SAMPLE, 1'b1, 1'b0, 32'h0, 1'b0, none};
        script[21] = '{ACT_SAMPLE, 1'b0, 1'b1, 32'h0, 1'b0, none};
        script[22] = '{ACT_SET_POSITION, 1'b0, 1'b0, 32'h0, 1'b1,
                       '{32'd0, 32'd0, STEP_REV, 32'd11, 1'b0}};

        ph_scale = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     $urandom, 32'h0000_0000};
        ph_tx = '{0, 73, 0, 16, 0, 16};
        ph_rx = '{0, 0, 73, 16, 0, 16};
        ph_len = '{260, 260, 260, 260, 250, 250};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            offer(script[i].act, script[i].a, script[i].b, script[i].np,
                  script[i].typed, script[i].given);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_scale(ph_scale[p]);
            tx_idle_pct = ph_tx[p];
            rx_stall_pct = ph_rx[p];
            if (p == 0)
                hold_left = 80;
            for (int i = 0; i < ph_len[p]; i++)
            begin
                if (p == 1 && i == 130)
                    drain();
                next_random(act, a, b, np);
                offer(act, a, b, np, 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0)
            $display("** quadrature_position_tracker_unit: PASSED **");
        else
            $display("** quadrature_position_tracker_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
